### rtl/sp2w_pkg.sv
// sp2w_pkg: shared types and constants for the sonar polar-to-world transform
// holds the pipeline payload structs, the cordic arctangent table and the gain
// no dependencies
package sp2w_pkg;

  // fixed widths
  localparam int RangeW = 16;
  localparam int AngW   = 16;
  localparam int PosW   = 24;
  localparam int VecW   = 32;   // cordic x/y, range << 14 grown by cordic gain
  localparam int ZW     = 32;   // residual angle, 2^32 per turn
  localparam int ProdW  = 63;   // vector times gain constant
  localparam int RndW   = 19;   // rounded product in q.8
  localparam int SumW   = 25;   // rounded product plus robot position

  // register defaults and register indexes
  localparam logic [15:0] MinRangeReset  = 16'd26;
  localparam logic [15:0] MapMarginReset = 16'd51;
  localparam logic        RegMinRange    = 1'b0;
  localparam logic        RegMapMargin   = 1'b1;

  // gain correction, 0.60725... in q30
  localparam logic signed [30:0] GainQ30 = 31'sd652032874;

  // rounding half for the final shift by 44
  localparam logic signed [ProdW-1:0] RoundHalf = 63'sd1 <<< 43;

  // saturation limits
  localparam logic signed [SumW-1:0] OutMax = 25'sd8388607;
  localparam logic signed [SumW-1:0] OutMin = -25'sd8388608;

  // item moving through the cordic stages
  typedef struct packed {
    logic                   det;
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic signed [ZW-1:0]   z;
    logic signed [PosW-1:0] rx;
    logic signed [PosW-1:0] ry;
    logic signed [PosW-1:0] rz;
  } stage_t;

  // item after the gain multiply
  typedef struct packed {
    logic                    det;
    logic signed [ProdW-1:0] px;
    logic signed [ProdW-1:0] py;
    logic signed [PosW-1:0]  rx;
    logic signed [PosW-1:0]  ry;
    logic signed [PosW-1:0]  rz;
  } prod_t;

  // finished result
  typedef struct packed {
    logic                   mark;
    logic                   det;
    logic signed [PosW-1:0] wz;
    logic signed [PosW-1:0] wy;
    logic signed [PosW-1:0] wx;
  } res_t;

  // atan(2^-i) in units of 2^32 per turn, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_unit(input logic [4:0] idx);
    logic signed [ZW-1:0] a;
    unique case (idx)
      5'd0:  a = 32'sd536870912;
      5'd1:  a = 32'sd316933406;
      5'd2:  a = 32'sd167458907;
      5'd3:  a = 32'sd85004756;
      5'd4:  a = 32'sd42667331;
      5'd5:  a = 32'sd21354465;
      5'd6:  a = 32'sd10679838;
      5'd7:  a = 32'sd5340245;
      5'd8:  a = 32'sd2670163;
      5'd9:  a = 32'sd1335087;
      5'd10: a = 32'sd667544;
      5'd11: a = 32'sd333772;
      5'd12: a = 32'sd166886;
      5'd13: a = 32'sd83443;
      5'd14: a = 32'sd41722;
      5'd15: a = 32'sd20861;
      5'd16: a = 32'sd10430;
      5'd17: a = 32'sd5215;
      5'd18: a = 32'sd2608;
      5'd19: a = 32'sd1304;
      5'd20: a = 32'sd652;
      5'd21: a = 32'sd326;
      5'd22: a = 32'sd163;
      5'd23: a = 32'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### rtl/sp2w_cordic_stage.sv
// sp2w_cordic_stage: one registered cordic rotation micro-step
// shift amount and arctangent entry follow the SHIFT parameter
// depends on sp2w_pkg
module sp2w_cordic_stage #(
  parameter int SHIFT = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  sp2w_pkg::stage_t in_data,
  output logic             out_valid,
  output sp2w_pkg::stage_t out_data
);

  localparam logic signed [sp2w_pkg::ZW-1:0] Atan = sp2w_pkg::atan_unit(5'(SHIFT));

  sp2w_pkg::stage_t data_next;
  logic signed [sp2w_pkg::VecW-1:0] dx;
  logic signed [sp2w_pkg::VecW-1:0] dy;

  // rotate toward zero residual angle
  always_comb begin
    dx = in_data.y >>> SHIFT;
    dy = in_data.x >>> SHIFT;
    data_next = in_data;
    if (!in_data.z[sp2w_pkg::ZW-1]) begin
      data_next.x = in_data.x - dx;
      data_next.y = in_data.y + dy;
      data_next.z = in_data.z - Atan;
    end else begin
      data_next.x = in_data.x + dx;
      data_next.y = in_data.y - dy;
      data_next.z = in_data.z + Atan;
    end
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

### rtl/sp2w_post.sv
// sp2w_post: gain correction, rounding, position add, saturation and map flag
// two register stages: multiply, then round/add/saturate/compare
// depends on sp2w_pkg
module sp2w_post (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [15:0]      map_margin,
  input  logic             in_valid,
  input  sp2w_pkg::stage_t in_data,
  output logic             out_valid,
  output sp2w_pkg::res_t   out_data
);

  sp2w_pkg::prod_t prod;
  logic            prod_valid;
  sp2w_pkg::res_t  res_next;

  logic signed [sp2w_pkg::ProdW-1:0] rnd_x;
  logic signed [sp2w_pkg::ProdW-1:0] rnd_y;
  logic signed [sp2w_pkg::SumW-1:0]  sum_x;
  logic signed [sp2w_pkg::SumW-1:0]  sum_y;
  logic signed [sp2w_pkg::PosW-1:0]  sat_x;
  logic signed [sp2w_pkg::PosW-1:0]  sat_y;
  logic signed [sp2w_pkg::SumW-1:0]  marg;

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (en) begin
      prod_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod.det <= in_data.det;
      prod.px  <= sp2w_pkg::ProdW'(in_data.x) * sp2w_pkg::ProdW'(sp2w_pkg::GainQ30);
      prod.py  <= sp2w_pkg::ProdW'(in_data.y) * sp2w_pkg::ProdW'(sp2w_pkg::GainQ30);
      prod.rx  <= in_data.rx;
      prod.ry  <= in_data.ry;
      prod.rz  <= in_data.rz;
    end
  end

  // round to q.8, add position, saturate, evaluate map flag
  always_comb begin
    rnd_x = prod.px + sp2w_pkg::RoundHalf;
    rnd_y = prod.py + sp2w_pkg::RoundHalf;
    sum_x = sp2w_pkg::SumW'($signed(rnd_x[sp2w_pkg::ProdW-1:44]))
            + sp2w_pkg::SumW'(prod.rx);
    sum_y = sp2w_pkg::SumW'($signed(rnd_y[sp2w_pkg::ProdW-1:44]))
            + sp2w_pkg::SumW'(prod.ry);
    if (sum_x > sp2w_pkg::OutMax)      sat_x = sp2w_pkg::PosW'(sp2w_pkg::OutMax);
    else if (sum_x < sp2w_pkg::OutMin) sat_x = sp2w_pkg::PosW'(sp2w_pkg::OutMin);
    else                               sat_x = sum_x[sp2w_pkg::PosW-1:0];
    if (sum_y > sp2w_pkg::OutMax)      sat_y = sp2w_pkg::PosW'(sp2w_pkg::OutMax);
    else if (sum_y < sp2w_pkg::OutMin) sat_y = sp2w_pkg::PosW'(sp2w_pkg::OutMin);
    else                               sat_y = sum_y[sp2w_pkg::PosW-1:0];

    res_next.det = prod.det;
    if (prod.det) begin
      res_next.wx = sat_x;
      res_next.wy = sat_y;
      res_next.wz = prod.rz;
    end else begin
      res_next.wx = '0;
      res_next.wy = '0;
      res_next.wz = '0;
    end
    marg = $signed({9'b0, map_margin});
    res_next.mark = !((sp2w_pkg::SumW'(res_next.wx) < marg)
                      && (sp2w_pkg::SumW'(res_next.wy) < marg));
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= res_next;
    end
  end

endmodule

### rtl/sp2w_skid.sv
// sp2w_skid: two-entry output skid buffer with a registered ready
// decouples the pipeline stall from the downstream ready
// no package dependencies
module sp2w_skid #(
  parameter int W = 74
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic         spare_valid;
  logic [W-1:0] spare_data;

  assign in_ready = !spare_valid;

  // output register and spare entry control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (spare_valid) begin
        out_valid   <= 1'b1;
        spare_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid && !spare_valid) begin
      spare_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= spare_valid ? spare_data : in_data;
    end
    if (out_valid && !out_ready && !spare_valid) begin
      spare_data <= in_data;
    end
  end

endmodule

### rtl/sonar_polar_to_world.sv
// sonar_polar_to_world: top level, entry stage, config registers and pipeline
// instantiates sp2w_cordic_stage, sp2w_post and sp2w_skid
// depends on sp2w_pkg
//
// Places one sonar detection (range, bearing) in the world frame using the
// robot pose. The range vector is rotated by bearing + yaw with a quadrant
// pre-rotation and a pipelined CORDIC of CORDIC_STAGES stages, gain corrected,
// rounded to Q.8 and added to the robot position with 24-bit saturation.
// One item is accepted every cycle while s_tready is high; each result passes
// the entry stage (loaded at the accepting edge), one register per CORDIC
// stage, the gain multiply, round/add/saturate and the skid output register,
// and a stall holds every stage in place. A two-entry
// skid buffer at the output keeps s_tready registered. Ranges below min_range
// give a zero point with detected low.
module sonar_polar_to_world #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic         clk,
  input  logic         rst,
  // fields from bit 0: range[15:0], bearing[31:16], robot_x[55:32],
  // robot_y[79:56], robot_z[103:80], yaw[119:104]
  input  logic [119:0] s_tdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // fields from bit 0: world_x[23:0], world_y[47:24], world_z[71:48]
  output logic [71:0]  m_tdata,
  // fields from bit 0: detected[0], mark_map[1]
  output logic [1:0]   m_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_wdata
);

  localparam int ResW = $bits(sp2w_pkg::res_t);

  logic [15:0] min_range;
  logic [15:0] map_margin;
  logic        en;

  logic [15:0]  range;
  logic [15:0]  bearing;
  logic [15:0]  yaw;
  logic [15:0]  ang;
  logic [15:0]  ang_q;
  logic [15:0]  resid;
  logic         flip;
  logic         det;
  logic signed [sp2w_pkg::VecW-1:0] x_start;

  sp2w_pkg::stage_t pipe  [0:CORDIC_STAGES];
  logic             pvalid[0:CORDIC_STAGES];
  sp2w_pkg::stage_t entry_next;

  logic           post_valid;
  sp2w_pkg::res_t post_data;
  logic [ResW-1:0] out_bits;
  sp2w_pkg::res_t  out_res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_range  <= sp2w_pkg::MinRangeReset;
      map_margin <= sp2w_pkg::MapMarginReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sp2w_pkg::RegMinRange:  min_range  <= cfg_wdata;
        sp2w_pkg::RegMapMargin: map_margin <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // the whole pipeline advances while the skid buffer has room
  assign s_tready = en;

  // entry: combined angle, quadrant pre-rotation, start vector
  always_comb begin
    range   = s_tdata[15:0];
    bearing = s_tdata[31:16];
    yaw     = s_tdata[119:104];
    ang     = bearing + yaw;
    ang_q   = ang + 16'h4000;
    flip    = ang_q[15];
    resid   = flip ? (ang - 16'h8000) : ang;
    det     = range >= min_range;
    x_start = $signed({2'b00, range, 14'b0});

    entry_next.det = det;
    if (!det)      entry_next.x = '0;
    else if (flip) entry_next.x = -x_start;
    else           entry_next.x = x_start;
    entry_next.y  = '0;
    entry_next.z  = $signed({resid, 16'b0});
    entry_next.rx = $signed(s_tdata[55:32]);
    entry_next.ry = $signed(s_tdata[79:56]);
    entry_next.rz = $signed(s_tdata[103:80]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid[0] <= 1'b0;
    end else if (en) begin
      pvalid[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0] <= entry_next;
    end
  end

  // cordic stages
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    sp2w_cordic_stage #(
      .SHIFT(k)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (pvalid[k]),
      .in_data  (pipe[k]),
      .out_valid(pvalid[k+1]),
      .out_data (pipe[k+1])
    );
  end

  // gain, rounding, position add and map flag
  sp2w_post u_post (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .map_margin(map_margin),
    .in_valid  (pvalid[CORDIC_STAGES]),
    .in_data   (pipe[CORDIC_STAGES]),
    .out_valid (post_valid),
    .out_data  (post_data)
  );

  // output skid buffer
  sp2w_skid #(
    .W(ResW)
  ) u_skid (
    .clk      (clk),
    .rst      (rst),
    .in_valid (post_valid),
    .in_ready (en),
    .in_data  (post_data),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (out_bits)
  );

  assign out_res = out_bits;
  assign m_tdata = {out_res.wz, out_res.wy, out_res.wx};
  assign m_tuser = {out_res.mark, out_res.det};

`ifndef SYNTHESIS
  // a stalled pipeline means the output holds an item
  a_stall_has_output: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("pipeline stalled with empty output");

  // an ignored detection carries a zero point
  a_ignored_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == 72'd0)
    else $error("ignored detection with nonzero point");

  // nothing comes out and the input is ready right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !m_tvalid && s_tready)
    else $error("output valid or stalled right after reset");
`endif

endmodule
